### rtl/efe_pkg.sv
// Exhaust flame effect: shared types, constants and the sequencer microprogram.
// Used by efe_seq, efe_dpath and exhaust_flame_effect_fsm; depends on nothing.
package efe_pkg;

  // Field widths
  localparam int THR_W      = 11;
  localparam int LVL_W      = 8;
  localparam int RND_W      = 8;
  localparam int CHC_W      = 7;
  localparam int KIND_W     = 2;
  localparam int PROF_W     = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int CNT_W      = $clog2(RND_W);
  localparam int PC_W       = 5;
  localparam int OP_W       = 4;
  localparam int CND_W      = 4;

  // Flame kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIM    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BRIGHT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POP_LEVEL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_LEVEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTENSITY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_PROFILE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_PROFILE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POP_PROFILE    = 3'd6;

  // Configuration reset values
  localparam logic [THR_W-1:0]  POP_LEVEL_RST     = 11'd1900;
  localparam logic [THR_W-1:0]  BRIGHT_LEVEL_RST  = 11'd1700;
  localparam logic [THR_W-1:0]  DIM_LEVEL_RST     = 11'd1550;
  localparam logic [LVL_W-1:0]  MAX_INTENSITY_RST = 8'd255;
  localparam logic [PROF_W-1:0] PROFILE_RST       = 40'd0;

  // Datapath operations
  localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD_STEP   = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD_DIM    = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD_BRIGHT = 4'd3;
  localparam logic [OP_W-1:0] OP_LOAD_POP    = 4'd4;
  localparam logic [OP_W-1:0] OP_MOD_ITER    = 4'd5;
  localparam logic [OP_W-1:0] OP_FIN_STEP    = 4'd6;
  localparam logic [OP_W-1:0] OP_FIN_START   = 4'd7;
  localparam logic [OP_W-1:0] OP_END_KIND    = 4'd8;
  localparam logic [OP_W-1:0] OP_DONE        = 4'd9;

  // Jump conditions
  localparam logic [CND_W-1:0] CND_ALWAYS   = 4'd0;
  localparam logic [CND_W-1:0] CND_RISE     = 4'd1;
  localparam logic [CND_W-1:0] CND_POPRST   = 4'd2;
  localparam logic [CND_W-1:0] CND_ACTIVE   = 4'd3;
  localparam logic [CND_W-1:0] CND_LVL0     = 4'd4;
  localparam logic [CND_W-1:0] CND_THRPOP   = 4'd5;
  localparam logic [CND_W-1:0] CND_BRIGHT   = 4'd6;
  localparam logic [CND_W-1:0] CND_DIM      = 4'd7;
  localparam logic [CND_W-1:0] CND_MODLAST  = 4'd8;

  // Program labels
  localparam logic [PC_W-1:0] PC_ENTRY        = 5'd0;
  localparam logic [PC_W-1:0] PC_CHK_POPRST   = 5'd1;
  localparam logic [PC_W-1:0] PC_CHK_ACTIVE   = 5'd2;
  localparam logic [PC_W-1:0] PC_CHK_LVL0     = 5'd3;
  localparam logic [PC_W-1:0] PC_STEP_LOAD    = 5'd4;
  localparam logic [PC_W-1:0] PC_STEP_RUN     = 5'd5;
  localparam logic [PC_W-1:0] PC_STEP_FIN     = 5'd6;
  localparam logic [PC_W-1:0] PC_IDLE_POP     = 5'd7;
  localparam logic [PC_W-1:0] PC_IDLE_BRIGHT  = 5'd8;
  localparam logic [PC_W-1:0] PC_IDLE_DIM     = 5'd9;
  localparam logic [PC_W-1:0] PC_IDLE_NONE    = 5'd10;
  localparam logic [PC_W-1:0] PC_RESTART      = 5'd11;
  localparam logic [PC_W-1:0] PC_START_BRIGHT = 5'd12;
  localparam logic [PC_W-1:0] PC_START_POP    = 5'd13;
  localparam logic [PC_W-1:0] PC_START_DIM    = 5'd14;
  localparam logic [PC_W-1:0] PC_START_RUN    = 5'd15;
  localparam logic [PC_W-1:0] PC_START_FIN    = 5'd16;
  localparam logic [PC_W-1:0] PC_KILL         = 5'd17;
  localparam logic [PC_W-1:0] PC_FINISH       = 5'd18;

  typedef struct packed {
    logic [THR_W-1:0] throttle;
    logic [RND_W-1:0] rand_start;
    logic [RND_W-1:0] rand_step;
    logic [CHC_W-1:0] rand_chance;
  } efe_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] flame_kind;
    logic [LVL_W-1:0]  flame_level;
  } efe_out_t;

  typedef struct packed {
    logic [THR_W-1:0]  pop_level;
    logic [THR_W-1:0]  bright_level;
    logic [THR_W-1:0]  dim_level;
    logic [LVL_W-1:0]  max_intensity;
    logic [PROF_W-1:0] dim_profile;
    logic [PROF_W-1:0] bright_profile;
    logic [PROF_W-1:0] pop_profile;
  } cfg_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic rise;
    logic pop_restart;
    logic active;
    logic level_zero;
    logic thr_pop;
    logic bright_start;
    logic dim_start;
    logic mod_last;
  } flags_t;

  // Command from sequencer to datapath
  typedef struct packed {
    logic            exec;
    logic [OP_W-1:0] op;
  } ctl_t;

  // One microinstruction: operation, jump condition, inversion, target
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cnd;
    logic             inv;
    logic [PC_W-1:0]  tgt;
  } ucw_t;

  function automatic ucw_t mk(input logic [OP_W-1:0] op, input logic [CND_W-1:0] cnd,
                              input logic inv, input logic [PC_W-1:0] tgt);
    ucw_t w;
    w.op  = op;
    w.cnd = cnd;
    w.inv = inv;
    w.tgt = tgt;
    return w;
  endfunction

  // Microprogram; CND_ALWAYS with inv set means fall through
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      PC_ENTRY:        w = mk(OP_NOP,         CND_RISE,    1'b0, PC_KILL);
      PC_CHK_POPRST:   w = mk(OP_NOP,         CND_POPRST,  1'b0, PC_RESTART);
      PC_CHK_ACTIVE:   w = mk(OP_NOP,         CND_ACTIVE,  1'b1, PC_IDLE_POP);
      PC_CHK_LVL0:     w = mk(OP_NOP,         CND_LVL0,    1'b0, PC_KILL);
      PC_STEP_LOAD:    w = mk(OP_LOAD_STEP,   CND_ALWAYS,  1'b1, PC_ENTRY);
      PC_STEP_RUN:     w = mk(OP_MOD_ITER,    CND_MODLAST, 1'b1, PC_STEP_RUN);
      PC_STEP_FIN:     w = mk(OP_FIN_STEP,    CND_ALWAYS,  1'b0, PC_FINISH);
      PC_IDLE_POP:     w = mk(OP_NOP,         CND_THRPOP,  1'b0, PC_START_POP);
      PC_IDLE_BRIGHT:  w = mk(OP_NOP,         CND_BRIGHT,  1'b0, PC_START_BRIGHT);
      PC_IDLE_DIM:     w = mk(OP_NOP,         CND_DIM,     1'b0, PC_START_DIM);
      PC_IDLE_NONE:    w = mk(OP_NOP,         CND_ALWAYS,  1'b0, PC_FINISH);
      PC_RESTART:      w = mk(OP_NOP,         CND_THRPOP,  1'b0, PC_START_POP);
      PC_START_BRIGHT: w = mk(OP_LOAD_BRIGHT, CND_ALWAYS,  1'b0, PC_START_RUN);
      PC_START_POP:    w = mk(OP_LOAD_POP,    CND_ALWAYS,  1'b0, PC_START_RUN);
      PC_START_DIM:    w = mk(OP_LOAD_DIM,    CND_ALWAYS,  1'b1, PC_ENTRY);
      PC_START_RUN:    w = mk(OP_MOD_ITER,    CND_MODLAST, 1'b1, PC_START_RUN);
      PC_START_FIN:    w = mk(OP_FIN_START,   CND_ALWAYS,  1'b0, PC_FINISH);
      PC_KILL:         w = mk(OP_END_KIND,    CND_ALWAYS,  1'b1, PC_ENTRY);
      PC_FINISH:       w = mk(OP_DONE,        CND_ALWAYS,  1'b1, PC_ENTRY);
      default:         w = mk(OP_DONE,        CND_ALWAYS,  1'b1, PC_ENTRY);
    endcase
    return w;
  endfunction

endpackage

### rtl/exhaust_flame_effect_fsm.sv
// Exhaust flame effect: top level with handshakes, configuration registers and
// output register. Depends on efe_pkg, efe_seq and efe_dpath.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one tick word: throttle and
//   three random draws. Output channel (out_valid/out_stall/out_data) returns one
//   word per tick with the flame kind and intensity after that tick.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one
//   register per handshake; cfg_ready is always high. Indexes beyond the list
//   are ignored. Write only while the block is idle.
// Sequencing:
//   A microprogram runs each tick, one control word per cycle while the final step
//   is not held for the output register. A rising throttle, an end at zero, an idle
//   tick, a step and a start take different paths; the remainder loop (one draw bit per
//   cycle) dominates. The output word is loaded by the final step, and the next tick
//   word can be taken in the same cycle that the output word appears.
// Reset (rst, synchronous): no flame, intensity 0, last throttle 0, registers
//   at their defaults, output empty.
// Stall: a finished word waits in the output register; the next tick is still
//   accepted and runs, and only its final step waits for the register to free.
module exhaust_flame_effect_fsm (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  efe_pkg::efe_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output efe_pkg::efe_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [efe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [efe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  efe_pkg::cfg_t                cfg;
  efe_pkg::flags_t              flags;
  efe_pkg::ctl_t                ctl;
  logic                         busy;
  logic                         start;
  logic                         out_free;
  logic                         done;
  logic [efe_pkg::KIND_W-1:0]   kind;
  logic [efe_pkg::LVL_W-1:0]    level;

  // Take a tick word whenever no program is running
  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign done      = ctl.exec && (ctl.op == efe_pkg::OP_DONE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pop_level      <= efe_pkg::POP_LEVEL_RST;
      cfg.bright_level   <= efe_pkg::BRIGHT_LEVEL_RST;
      cfg.dim_level      <= efe_pkg::DIM_LEVEL_RST;
      cfg.max_intensity  <= efe_pkg::MAX_INTENSITY_RST;
      cfg.dim_profile    <= efe_pkg::PROFILE_RST;
      cfg.bright_profile <= efe_pkg::PROFILE_RST;
      cfg.pop_profile    <= efe_pkg::PROFILE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        efe_pkg::CFG_POP_LEVEL:      cfg.pop_level      <= cfg_data[efe_pkg::THR_W-1:0];
        efe_pkg::CFG_BRIGHT_LEVEL:   cfg.bright_level   <= cfg_data[efe_pkg::THR_W-1:0];
        efe_pkg::CFG_DIM_LEVEL:      cfg.dim_level      <= cfg_data[efe_pkg::THR_W-1:0];
        efe_pkg::CFG_MAX_INTENSITY:  cfg.max_intensity  <= cfg_data[efe_pkg::LVL_W-1:0];
        efe_pkg::CFG_DIM_PROFILE:    cfg.dim_profile    <= cfg_data[efe_pkg::PROF_W-1:0];
        efe_pkg::CFG_BRIGHT_PROFILE: cfg.bright_profile <= cfg_data[efe_pkg::PROF_W-1:0];
        efe_pkg::CFG_POP_PROFILE:    cfg.pop_profile    <= cfg_data[efe_pkg::PROF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  efe_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .flags    (flags),
    .out_free (out_free),
    .ctl      (ctl),
    .busy     (busy)
  );

  efe_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_word (in_data),
    .cfg     (cfg),
    .ctl     (ctl),
    .flags   (flags),
    .kind    (kind),
    .level   (level)
  );

  // Output register: load on the final step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data.flame_kind  <= kind;
      out_data.flame_level <= level;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted word starts a program
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> busy)
    else $error("accepted word did not start the sequencer");

  // The final step never overwrites a waiting word
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !(out_valid && out_stall))
    else $error("result written over a stalled output word");

  // No datapath operation runs without a program
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !ctl.exec)
    else $error("datapath operation while idle");

  // Finishing a program always produces an output word
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    done |=> (out_valid && !busy))
    else $error("program ended without an output word");
`endif

endmodule

### rtl/efe_seq.sv
// Exhaust flame effect: microcode sequencer (step counter, condition select, jumps).
// Depends on efe_pkg for the microprogram, flag and command types.
module efe_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  efe_pkg::flags_t flags,
  input  logic            out_free,
  output efe_pkg::ctl_t   ctl,
  output logic            busy
);

  logic [efe_pkg::PC_W-1:0] pc;
  efe_pkg::ucw_t            uw;
  logic                     cond;
  logic                     hold;

  // Fetch the current control word
  assign uw = efe_pkg::ucode(pc);

  // Select the jump condition
  always_comb begin
    case (uw.cnd)
      efe_pkg::CND_ALWAYS:  cond = 1'b1;
      efe_pkg::CND_RISE:    cond = flags.rise;
      efe_pkg::CND_POPRST:  cond = flags.pop_restart;
      efe_pkg::CND_ACTIVE:  cond = flags.active;
      efe_pkg::CND_LVL0:    cond = flags.level_zero;
      efe_pkg::CND_THRPOP:  cond = flags.thr_pop;
      efe_pkg::CND_BRIGHT:  cond = flags.bright_start;
      efe_pkg::CND_DIM:     cond = flags.dim_start;
      efe_pkg::CND_MODLAST: cond = flags.mod_last;
      default:              cond = 1'b0;
    endcase
  end

  // Hold the final step until the output register can take the word
  assign hold     = (uw.op == efe_pkg::OP_DONE) && !out_free;
  assign ctl.exec = busy && !hold;
  assign ctl.op   = uw.op;

  // Advance, jump or finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= efe_pkg::PC_ENTRY;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= efe_pkg::PC_ENTRY;
    end else if (ctl.exec) begin
      if (uw.op == efe_pkg::OP_DONE) begin
        busy <= 1'b0;
      end else if (cond ^ uw.inv) begin
        pc <= uw.tgt;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

### rtl/efe_dpath.sv
// Exhaust flame effect: datapath with flame state, serial remainder unit and clamp.
// Depends on efe_pkg; driven one operation per cycle by efe_seq while it does not hold the final step.
module efe_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  efe_pkg::efe_in_t            in_word,
  input  efe_pkg::cfg_t               cfg,
  input  efe_pkg::ctl_t               ctl,
  output efe_pkg::flags_t             flags,
  output logic [efe_pkg::KIND_W-1:0]  kind,
  output logic [efe_pkg::LVL_W-1:0]   level
);

  // Flame state
  logic [efe_pkg::KIND_W-1:0] kind_now;
  logic [efe_pkg::KIND_W-1:0] kind_before;
  logic [efe_pkg::LVL_W-1:0]  level_now;
  logic [efe_pkg::THR_W-1:0]  throttle_before;

  // Working registers
  efe_pkg::efe_in_t           item;
  logic [efe_pkg::KIND_W-1:0] sel_kind;
  logic [efe_pkg::LVL_W-1:0]  lo;
  logic [efe_pkg::LVL_W-1:0]  span;
  logic                       range_ok;
  logic [efe_pkg::RND_W-1:0]  dq;
  logic [efe_pkg::LVL_W-1:0]  rem;
  logic [efe_pkg::CNT_W-1:0]  cnt;
  logic [efe_pkg::LVL_W-1:0]  chance;

  logic [efe_pkg::KIND_W-1:0] load_kind;
  logic [efe_pkg::PROF_W-1:0] prof;
  logic                       is_step;
  logic [efe_pkg::LVL_W-1:0]  rng_lo;
  logic [efe_pkg::LVL_W-1:0]  rng_hi;
  logic [efe_pkg::RND_W-1:0]  draw;
  logic [efe_pkg::LVL_W:0]    r9;
  logic [efe_pkg::LVL_W:0]    diff9;
  logic [efe_pkg::LVL_W-1:0]  rem_iter;
  logic [efe_pkg::LVL_W-1:0]  pick;
  logic                       halve;
  logic signed [efe_pkg::LVL_W+1:0] lvl_s;
  logic signed [efe_pkg::LVL_W+1:0] nxt;
  logic [efe_pkg::LVL_W-1:0]  clamped;
  logic                       falling;

  // Pick the profile for the kind being loaded
  always_comb begin
    case (ctl.op)
      efe_pkg::OP_LOAD_DIM:    load_kind = efe_pkg::KIND_DIM;
      efe_pkg::OP_LOAD_BRIGHT: load_kind = efe_pkg::KIND_BRIGHT;
      efe_pkg::OP_LOAD_POP:    load_kind = efe_pkg::KIND_POP;
      default:                 load_kind = kind_now;
    endcase
    case (load_kind)
      efe_pkg::KIND_DIM:    prof = cfg.dim_profile;
      efe_pkg::KIND_BRIGHT: prof = cfg.bright_profile;
      default:              prof = cfg.pop_profile;
    endcase
    is_step = (ctl.op == efe_pkg::OP_LOAD_STEP);
    rng_lo  = is_step ? prof[23:16] : prof[7:0];
    rng_hi  = is_step ? prof[31:24] : prof[15:8];
    draw    = is_step ? item.rand_step : item.rand_start;
  end

  // One restoring remainder step: shift in a dividend bit, subtract if it fits
  always_comb begin
    r9       = {rem, dq[efe_pkg::RND_W-1]};
    diff9    = r9 - {1'b0, span};
    rem_iter = (r9 >= {1'b0, span}) ? diff9[efe_pkg::LVL_W-1:0] : r9[efe_pkg::LVL_W-1:0];
  end

  // Range value, then the step with optional halve-and-reverse and the clamp
  always_comb begin
    pick  = range_ok ? lo + rem : lo;
    halve = ({1'b0, item.rand_chance} <= chance);
    lvl_s = $signed({2'b00, level_now});
    if (halve) begin
      nxt = lvl_s + $signed({3'b000, pick[efe_pkg::LVL_W-1:1]});
    end else begin
      nxt = lvl_s - $signed({2'b00, pick});
    end
    if (nxt > $signed({2'b00, cfg.max_intensity})) begin
      clamped = cfg.max_intensity;
    end else if (nxt < 0) begin
      clamped = '0;
    end else begin
      clamped = nxt[efe_pkg::LVL_W-1:0];
    end
  end

  // Decision flags for the sequencer
  always_comb begin
    falling            = item.throttle < throttle_before;
    flags.rise         = item.throttle > throttle_before;
    flags.pop_restart  = (kind_before == efe_pkg::KIND_POP) && (level_now == '0);
    flags.active       = (kind_now != efe_pkg::KIND_NONE);
    flags.level_zero   = (level_now == '0);
    flags.thr_pop      = item.throttle >= cfg.pop_level;
    flags.bright_start = (throttle_before >= cfg.bright_level) && falling;
    flags.dim_start    = (throttle_before >= cfg.dim_level) && falling;
    flags.mod_last     = (cnt == '1);
  end

  // Update the flame state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_now        <= efe_pkg::KIND_NONE;
      kind_before     <= efe_pkg::KIND_NONE;
      level_now       <= '0;
      throttle_before <= '0;
    end else if (ctl.exec) begin
      case (ctl.op)
        efe_pkg::OP_FIN_STEP: begin
          level_now <= clamped;
        end
        efe_pkg::OP_FIN_START: begin
          kind_before <= kind_now;
          kind_now    <= sel_kind;
          level_now   <= pick;
        end
        efe_pkg::OP_END_KIND: begin
          kind_before <= kind_now;
          kind_now    <= efe_pkg::KIND_NONE;
        end
        efe_pkg::OP_DONE: begin
          throttle_before <= item.throttle;
        end
        default: begin
        end
      endcase
    end
  end

  // Latch the word and run the remainder unit
  always_ff @(posedge clk) begin
    if (start) begin
      item <= in_word;
    end
    if (ctl.exec) begin
      case (ctl.op)
        efe_pkg::OP_LOAD_STEP, efe_pkg::OP_LOAD_DIM,
        efe_pkg::OP_LOAD_BRIGHT, efe_pkg::OP_LOAD_POP: begin
          sel_kind <= load_kind;
          lo       <= rng_lo;
          span     <= rng_hi - rng_lo;
          range_ok <= rng_hi > rng_lo;
          dq       <= draw;
          rem      <= '0;
          cnt      <= '0;
          chance   <= prof[39:32];
        end
        efe_pkg::OP_MOD_ITER: begin
          rem <= rem_iter;
          dq  <= {dq[efe_pkg::RND_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign kind  = kind_now;
  assign level = level_now;

endmodule

### tb/exhaust_flame_effect_fsm_test.sv
// Self-checking testbench for the exhaust flame effect block: drives tick words,
// predicts each flame word in a local model and compares what comes out.
// Depends on efe_pkg and exhaust_flame_effect_fsm only.
module exhaust_flame_effect_fsm_test;
  timeunit 1ns;
  timeprecision 1ps;
  import efe_pkg::*;

  localparam int IDLE_LIMIT     = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int SQUEEZE_AT     = 150;
  localparam int RANDOM_TICKS   = 80;
  localparam int SHOWN_ERRORS   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  efe_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  efe_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Tick words waiting to be sent and flame words still owed by the block
  efe_in_t  ticks_pending[$];
  efe_out_t flame_expected[$];

  // Local flame model: register copy and state
  cfg_t              regs_mirror;
  logic [KIND_W-1:0] kind_cur;
  logic [KIND_W-1:0] kind_prev;
  logic [LVL_W-1:0]  level_cur;
  logic [THR_W-1:0]  thr_prev;

  int   idle_max     = 8;
  int   gap_left     = 0;
  int   hold_left    = 0;
  int   ticks_taken  = 0;
  int   n_fail       = 0;
  int   quiet_cycles = 0;
  int   squeeze_left = 0;
  logic squeeze_on   = 1'b0;
  logic squeeze_done = 1'b0;
  int   walk_thr     = 0;

  exhaust_flame_effect_fsm i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // min plus draw modulo span; min alone when the span is empty
  function automatic logic [7:0] draw_span(input logic [7:0] lo, input logic [7:0] hi,
                                           input logic [7:0] draw);
    if (hi <= lo) return lo;
    return lo + draw % (hi - lo);
  endfunction

  function automatic logic [PROF_W-1:0] profile_for(input logic [KIND_W-1:0] kind);
    case (kind)
      KIND_DIM:    return regs_mirror.dim_profile;
      KIND_BRIGHT: return regs_mirror.bright_profile;
      default:     return regs_mirror.pop_profile;
    endcase
  endfunction

  // Start intensity is not clamped to the maximum
  function automatic void light_flame(input logic [KIND_W-1:0] kind, input logic [7:0] draw);
    logic [PROF_W-1:0] prof;
    prof      = profile_for(kind);
    kind_prev = kind_cur;
    kind_cur  = kind;
    level_cur = draw_span(prof[7:0], prof[15:8], draw);
  endfunction

  // Advance the model by one tick and return the flame word it should give
  function automatic efe_out_t flame_tick(input efe_in_t w);
    logic [PROF_W-1:0] prof;
    int                change;
    int                nxt;
    efe_out_t          r;
    if (w.throttle > thr_prev) begin
      kind_prev = kind_cur;
      kind_cur  = KIND_NONE;
    end else if (kind_prev == KIND_POP && level_cur == '0) begin
      light_flame(w.throttle >= regs_mirror.pop_level ? KIND_POP : KIND_BRIGHT, w.rand_start);
    end else if (kind_cur != KIND_NONE) begin
      if (level_cur == '0) begin
        kind_prev = kind_cur;
        kind_cur  = KIND_NONE;
      end else begin
        prof   = profile_for(kind_cur);
        change = int'(draw_span(prof[23:16], prof[31:24], w.rand_step));
        // halve and reverse the step when the chance draw hits
        if (w.rand_chance <= prof[39:32]) change = -(change / 2);
        nxt = int'(level_cur) - change;
        if (nxt > int'(regs_mirror.max_intensity)) nxt = int'(regs_mirror.max_intensity);
        else if (nxt < 0) nxt = 0;
        level_cur = nxt[7:0];
      end
    end else if (w.throttle >= regs_mirror.pop_level) begin
      light_flame(KIND_POP, w.rand_start);
    end else if (thr_prev >= regs_mirror.bright_level && w.throttle < thr_prev) begin
      light_flame(KIND_BRIGHT, w.rand_start);
    end else if (thr_prev >= regs_mirror.dim_level && w.throttle < thr_prev) begin
      light_flame(KIND_DIM, w.rand_start);
    end
    thr_prev      = w.throttle;
    r.flame_kind  = kind_cur;
    r.flame_level = level_cur;
    return r;
  endfunction

  // Write one register through the config channel and mirror it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_POP_LEVEL:      regs_mirror.pop_level      = val[THR_W-1:0];
      CFG_BRIGHT_LEVEL:   regs_mirror.bright_level   = val[THR_W-1:0];
      CFG_DIM_LEVEL:      regs_mirror.dim_level      = val[THR_W-1:0];
      CFG_MAX_INTENSITY:  regs_mirror.max_intensity  = val[LVL_W-1:0];
      CFG_DIM_PROFILE:    regs_mirror.dim_profile    = val[PROF_W-1:0];
      CFG_BRIGHT_PROFILE: regs_mirror.bright_profile = val[PROF_W-1:0];
      CFG_POP_PROFILE:    regs_mirror.pop_profile    = val[PROF_W-1:0];
      default: ;
    endcase
  endtask

  // Write all registers; junk fills the unused upper data bits at random
  task automatic program_regs(input logic [THR_W-1:0] pop, input logic [THR_W-1:0] bright,
                              input logic [THR_W-1:0] dim, input logic [LVL_W-1:0] max_lvl,
                              input logic [PROF_W-1:0] dim_p, input logic [PROF_W-1:0] bright_p,
                              input logic [PROF_W-1:0] pop_p, input logic junk);
    logic [63:0] upper;
    upper = junk ? {$urandom, $urandom} : '0;
    write_reg(CFG_POP_LEVEL,      {upper[CFG_DATA_W-THR_W-1:0], pop});
    write_reg(CFG_BRIGHT_LEVEL,   {upper[CFG_DATA_W-THR_W-1:0], bright});
    write_reg(CFG_DIM_LEVEL,      {upper[CFG_DATA_W-THR_W-1:0], dim});
    write_reg(CFG_MAX_INTENSITY,  {upper[CFG_DATA_W-LVL_W-1:0], max_lvl});
    write_reg(CFG_DIM_PROFILE,    dim_p);
    write_reg(CFG_BRIGHT_PROFILE, bright_p);
    write_reg(CFG_POP_PROFILE,    pop_p);
  endtask

  // Profile bytes from the low end: start min, start max, step min, step max, chance
  function automatic logic [PROF_W-1:0] rand_profile();
    logic [7:0] start_lo;
    logic [7:0] start_hi;
    logic [7:0] step_lo;
    logic [7:0] step_hi;
    logic [7:0] chance;
    start_lo = 8'($urandom);
    start_hi = 8'($urandom);
    step_lo  = 8'($urandom_range(0, 40));
    step_hi  = step_lo + 8'($urandom_range(0, 100));
    chance   = 8'($urandom_range(0, 100));
    return {chance, step_hi, step_lo, start_hi, start_lo};
  endfunction

  task automatic add_tick(input int thr, input int r_start, input int r_step, input int r_chance);
    efe_in_t w;
    w.throttle    = THR_W'(thr);
    w.rand_start  = RND_W'(r_start);
    w.rand_step   = RND_W'(r_step);
    w.rand_chance = CHC_W'(r_chance);
    ticks_pending.push_back(w);
  endtask

  // Mostly falling throttle runs with occasional jumps, plus some raw noise
  task automatic add_random_ticks(input int count);
    int roll;
    int delta;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        add_tick($urandom, $urandom, $urandom, $urandom_range(0, 127));
      end else begin
        delta = $urandom_range(0, 150);
        if (roll < 60) walk_thr = (walk_thr > delta) ? walk_thr - delta : 0;
        else if (roll < 88) walk_thr = $urandom_range(0, 2047);
        else if (roll < 95) walk_thr = (walk_thr + delta > 2047) ? 2047 : walk_thr + delta;
        add_tick(walk_thr, $urandom, $urandom, $urandom_range(0, 99));
      end
    end
  endtask

  // Hold until every word is sent and answered, then let the block settle
  task automatic wait_idle();
    while (ticks_pending.size() != 0 || in_valid || flame_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: present tick words with a random gap after each accepted one
  always @(posedge clk) begin : drive_ticks
    int gap;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      flame_expected.push_back(flame_tick(in_data));
      ticks_taken <= ticks_taken + 1;
      gap = $urandom_range(0, idle_max);
      if (gap == 0 && ticks_pending.size() != 0) begin
        in_data <= ticks_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
        gap_left <= gap;
      end
    end else if (!in_valid) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (ticks_pending.size() != 0) begin
        in_data  <= ticks_pending.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: check each flame word against the oldest prediction, then stall a while
  always @(posedge clk) begin : collect_flames
    efe_out_t want;
    int       hold;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      hold = hold_left;
      if (out_valid && !out_stall) begin
        if (flame_expected.size() == 0) begin
          if (n_fail < SHOWN_ERRORS)
            $display("unexpected flame word: kind %0d level %0d",
                     out_data.flame_kind, out_data.flame_level);
          n_fail++;
        end else begin
          want = flame_expected.pop_front();
          if (out_data.flame_kind !== want.flame_kind ||
              out_data.flame_level !== want.flame_level) begin
            if (n_fail < SHOWN_ERRORS)
              $display("flame word mismatch: expected kind %0d level %0d, got kind %0d level %0d",
                       want.flame_kind, want.flame_level,
                       out_data.flame_kind, out_data.flame_level);
            n_fail++;
          end
        end
        hold = $urandom_range(0, idle_max);
      end else if (hold != 0) begin
        hold--;
      end
      hold_left <= hold;
      out_stall <= (hold != 0) || squeeze_on;
    end
  end

  // Hold the output off once for a long stretch so the input backs up
  always @(posedge clk) begin : squeeze_output
    if (rst) begin
      squeeze_on   <= 1'b0;
      squeeze_left <= 0;
    end else if (squeeze_left != 0) begin
      squeeze_left <= squeeze_left - 1;
      squeeze_on   <= (squeeze_left != 1);
    end else if (!squeeze_done && ticks_taken >= SQUEEZE_AT) begin
      squeeze_left <= SQUEEZE_CYCLES;
      squeeze_on   <= 1'b1;
      squeeze_done <= 1'b1;
    end
  end

  // Drop the run when nothing moves on any channel for too long
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_test
    regs_mirror.pop_level      = POP_LEVEL_RST;
    regs_mirror.bright_level   = BRIGHT_LEVEL_RST;
    regs_mirror.dim_level      = DIM_LEVEL_RST;
    regs_mirror.max_intensity  = MAX_INTENSITY_RST;
    regs_mirror.dim_profile    = PROFILE_RST;
    regs_mirror.bright_profile = PROFILE_RST;
    regs_mirror.pop_profile    = PROFILE_RST;
    kind_cur  = KIND_NONE;
    kind_prev = KIND_NONE;
    level_cur = '0;
    thr_prev  = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Default registers: zero profiles, so pop flames fade and restart at once
    @(negedge clk);
    add_tick(2047, 255, 0, 0);
    add_tick(2047, 0, 255, 99);
    add_tick(2047, 170, 85, 127);
    add_tick(1200, 0, 0, 0);
    add_tick(0, 255, 255, 99);
    wait_idle();

    program_regs(11'd1900, 11'd1700, 11'd1550, 8'd200,
                 {8'd30, 8'd20, 8'd1, 8'd60, 8'd10},
                 {8'd50, 8'd40, 8'd5, 8'd250, 8'd100},
                 {8'd99, 8'd255, 8'd0, 8'd255, 8'd200}, 1'b0);
    @(negedge clk);
    // bright start, plain step, reversed steps at and below the chance
    add_tick(1800, 17, 3, 99);
    add_tick(1800, 0, 0, 0);
    add_tick(1650, 77, 9, 80);
    add_tick(1640, 1, 200, 90);
    add_tick(1630, 2, 13, 0);
    add_tick(1630, 3, 255, 50);
    // kill on rise, bright start above the maximum, clamp down
    add_tick(2000, 4, 5, 6);
    add_tick(1560, 255, 1, 7);
    add_tick(1560, 9, 0, 0);
    // dim start, step to the floor, end at zero
    add_tick(1620, 8, 8, 8);
    add_tick(1590, 0, 255, 99);
    add_tick(1590, 11, 200, 99);
    add_tick(1590, 12, 12, 12);
    // pop start, fade to zero, end, restart as pop
    add_tick(2047, 255, 0, 127);
    add_tick(2047, 31, 7, 99);
    add_tick(2047, 0, 254, 127);
    add_tick(2047, 1, 1, 1);
    add_tick(2047, 7, 2, 2);
    wait_idle();

    // Typical thresholds, random profiles
    program_regs(THR_W'($urandom_range(1800, 2000)), THR_W'($urandom_range(1200, 1700)),
                 THR_W'($urandom_range(600, 1200)), LVL_W'($urandom_range(100, 255)),
                 rand_profile(), rand_profile(), rand_profile(), 1'b0);
    @(negedge clk);
    idle_max = 8;
    add_random_ticks(RANDOM_TICKS);
    wait_idle();

    // Top pop threshold, bottom bright and dim thresholds, saturated profiles, no random gaps on either side
    program_regs(11'd2047, 11'd0, 11'd0, 8'd255,
                 {PROF_W{1'b1}}, {PROF_W{1'b1}}, {PROF_W{1'b1}}, 1'b0);
    @(negedge clk);
    idle_max = 0;
    add_random_ticks(RANDOM_TICKS);
    wait_idle();

    // Bottom pop threshold, top bright and dim thresholds and zero maximum
    program_regs(11'd0, 11'd2047, 11'd2047, 8'd0,
                 rand_profile(), rand_profile(), rand_profile(), 1'b0);
    @(negedge clk);
    idle_max = 8;
    add_random_ticks(RANDOM_TICKS);
    wait_idle();

    // Fully random registers with junk upper bits and a write to the spare index
    write_reg(CFG_SPARE, CFG_DATA_W'({$urandom, $urandom}));
    program_regs(THR_W'($urandom_range(0, 2047)), THR_W'($urandom_range(0, 2047)),
                 THR_W'($urandom_range(0, 2047)), LVL_W'($urandom_range(0, 255)),
                 rand_profile(), rand_profile(), rand_profile(), 1'b1);
    @(negedge clk);
    idle_max = 3;
    add_random_ticks(RANDOM_TICKS);
    wait_idle();

    program_regs(THR_W'($urandom_range(1700, 2047)), THR_W'($urandom_range(1100, 1600)),
                 THR_W'($urandom_range(300, 1000)), LVL_W'($urandom_range(50, 255)),
                 rand_profile(), rand_profile(), rand_profile(), 1'b0);
    @(negedge clk);
    idle_max = 8;
    add_random_ticks(RANDOM_TICKS);
    wait_idle();

    if (flame_expected.size() != 0) n_fail++;
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/efe_pkg.sv
rtl/efe_seq.sv
rtl/efe_dpath.sv
rtl/exhaust_flame_effect_fsm.sv
tb/exhaust_flame_effect_fsm_test.sv
